@@ design/guarded_transition_fsm_engine_assert.svh @@
// Assertion macros for the guarded transition engine.
// Used by the controller and the top level; no other dependencies.
`ifndef GUARDED_TRANSITION_FSM_ENGINE_ASSERT_SVH
`define GUARDED_TRANSITION_FSM_ENGINE_ASSERT_SVH

// implication checked every cycle outside reset
`define GTF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// implication checked in the cycle after the antecedent
`define GTF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ design/gtf_pkg.sv @@
// Shared types and constants of the guarded transition engine.
// No dependencies.
package gtf_pkg;
  localparam int NumStates = 16;
  localparam int NumVars = 16;
  localparam int TransPerState = 4;
  localparam int CondsPerTrans = 4;
  localparam int StW = 5;
  localparam int TrW = 2;
  localparam int CnW = 2;
  localparam int NumSlots = NumStates * TransPerState;
  localparam int NumConds = NumSlots * CondsPerTrans;
  localparam int SlotW = 6;
  localparam int CondW = 8;
  localparam logic [StW-1:0] NoState = StW'(NumStates);

  localparam logic [2:0] CmdSetVar = 3'd0;
  localparam logic [2:0] CmdWrCond = 3'd1;
  localparam logic [2:0] CmdWrTrans = 3'd2;
  localparam logic [2:0] CmdEval = 3'd3;
  localparam logic [2:0] CmdReset = 3'd4;
  localparam logic [2:0] CmdSetCur = 3'd5;

  localparam logic [1:0] StsMoved = 2'd0;
  localparam logic [1:0] StsSame = 2'd1;
  localparam logic [1:0] StsNone = 2'd2;
  localparam logic [1:0] StsLoop = 2'd3;

  localparam logic [2:0] CmpEq = 3'd0;
  localparam logic [2:0] CmpNe = 3'd1;
  localparam logic [2:0] CmpGt = 3'd2;
  localparam logic [2:0] CmpGe = 3'd3;
  localparam logic [2:0] CmpLt = 3'd4;
  localparam logic [2:0] CmpLe = 3'd5;

  typedef struct packed {
    logic [2:0] cmd;
    logic [3:0] var_index;
    logic signed [31:0] value;
    logic [4:0] state_index;
    logic [1:0] trans_index;
    logic [1:0] cond_index;
    logic [2:0] comparator;
    logic [4:0] target_state;
    logic [2:0] cond_count;
    logic slot_valid;
  } item_t;

  // controller -> datapath
  typedef struct packed {
    logic start;       // latch item, run the immediate part
    logic clr_vars;    // clearing sweep step
    logic [3:0] clr_idx;
    logic load_trans;  // read transition slot (state, slot)
    logic load_cond;   // read condition for current transition
    logic eval_cond;   // condition data valid: compare
    logic hop;         // move walk to target
    logic finish;      // write result register
    logic [1:0] status;
  } ctrl_t;

  // datapath -> controller
  typedef struct packed {
    logic cur_none;
    logic slot_valid;
    logic [2:0] slot_count;
    logic cond_ok;
    logic tgt_none;
    logic tgt_visited;
    logic at_start;
  } stat_t;
endpackage

@@ design/guarded_transition_fsm_engine.sv @@
// Guarded transition state machine engine: top level.
// Uses gtf_pkg, gtf_ctrl, gtf_datapath and the assertion header.
//
// Usage: one command per slave transaction on s_axis; one result per command
// on m_axis. Commands: set variable, write condition, write transition,
// evaluate, reset, set current. start_state is written through cfg_we_i.
// From the accepting edge to m_axis_tvalid, writes and set current go straight
// to the done state and its result register; reset first sweeps the NumVars
// variables (one variable cleared a cycle). Evaluate steps, per hop, through a
// read and a check state per slot looked at and per tested condition, and a
// hop state, all limited by the single read port of each table memory.
// Throughput: one command at a time; s_axis_tready is high while idle, which
// includes the cycles in which a finished result still waits on m_axis.
// Reset (rst_ni low) clears all variables, invalidates all transition slots
// and loads state 0. A stalled receiver holds the result; the next command is
// taken but its result waits until the previous one has gone.
`include "guarded_transition_fsm_engine_assert.svh"
module guarded_transition_fsm_engine (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // cmd[2:0] var_index[6:3] value[38:7] state_index[43:39] trans_index[45:44]
  // cond_index[47:46] comparator[50:48] target_state[55:51] cond_count[58:56]
  // slot_valid[59], zero pad to 64
  input  logic [63:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // status[1:0] current_state[6:2] var_value[38:7], zero pad to 40
  output logic [39:0] m_axis_tdata,
  input  logic cfg_we_i,
  input  logic [4:0] cfg_wdata_i
);
  import gtf_pkg::*;

  item_t item;
  ctrl_t ctrl;
  stat_t stat;
  logic [1:0] tr, cd, sts;
  logic [4:0] start_q, cur;
  logic signed [31:0] var_v;
  logic idle, done, in_fire, valid_q;

  assign item.cmd = s_axis_tdata[2:0];
  assign item.var_index = s_axis_tdata[6:3];
  assign item.value = s_axis_tdata[38:7];
  assign item.state_index = s_axis_tdata[43:39];
  assign item.trans_index = s_axis_tdata[45:44];
  assign item.cond_index = s_axis_tdata[47:46];
  assign item.comparator = s_axis_tdata[50:48];
  assign item.target_state = s_axis_tdata[55:51];
  assign item.cond_count = s_axis_tdata[58:56];
  assign item.slot_valid = s_axis_tdata[59];

  assign s_axis_tready = idle;
  assign in_fire = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0;
      valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) start_q <= cfg_wdata_i;
      if (done) valid_q <= 1'b1;
      else if (m_axis_tready) valid_q <= 1'b0;
    end
  end

  gtf_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_fire_i(in_fire), .cmd_i(item.cmd),
    .out_busy_i(valid_q && !m_axis_tready), .stat_i(stat), .ctrl_o(ctrl),
    .trans_o(tr), .cond_o(cd), .idle_o(idle), .done_o(done)
  );

  gtf_datapath u_dp (
    .clk_i, .rst_ni, .item_i(item), .start_state_i(start_q), .ctrl_i(ctrl),
    .trans_i(tr), .cond_i(cd), .stat_o(stat), .status_o(sts), .cur_o(cur),
    .var_o(var_v)
  );

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata = {1'b0, var_v, cur, sts};

  `GTF_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
                   m_axis_tvalid)
  `GTF_ASSERT_IMP(a_cur_range, clk_i, rst_ni, m_axis_tvalid,
                  m_axis_tdata[6:2] <= 5'(NumStates))
  `GTF_ASSERT_IMP(a_ready_idle, clk_i, rst_ni, s_axis_tready, !done)
endmodule

@@ design/gtf_datapath.sv @@
// Datapath: variable file, transition and condition memories, walk registers.
// Depends on gtf_pkg.
module gtf_datapath (
  input  logic clk_i,
  input  logic rst_ni,
  input  gtf_pkg::item_t item_i,
  input  logic [4:0] start_state_i,
  input  gtf_pkg::ctrl_t ctrl_i,
  input  logic [1:0] trans_i,
  input  logic [1:0] cond_i,
  output gtf_pkg::stat_t stat_o,
  output logic [1:0] status_o,
  output logic [4:0] cur_o,
  output logic signed [31:0] var_o
);
  import gtf_pkg::*;

  item_t it_q;
  logic [31:0] vars_q [NumVars];
  logic [NumSlots-1:0] tvalid_q;
  logic [7:0] tmem [NumSlots];   // {count[2:0], target[4:0]}
  logic [38:0] cmem [NumConds];  // {var[3:0], cmp[2:0], konst}
  logic [7:0] trd_q;
  logic [38:0] crd_q;
  logic trd_v_q;
  logic [StW-1:0] cur_q, walk_q, tgt_q, res_cur_q;
  logic [NumStates:0] vis_q;
  logic ok_q;
  logic [1:0] status_q;
  logic signed [31:0] var_q;

  logic [SlotW-1:0] rd_slot, wr_slot;
  logic [CondW-1:0] rd_cond, wr_cond;
  logic signed [31:0] a, b;
  logic hold;

  assign rd_slot = {walk_q[3:0], trans_i};
  assign rd_cond = {walk_q[3:0], trans_i, cond_i};
  assign wr_slot = {item_i.state_index[3:0], item_i.trans_index};
  assign wr_cond = {item_i.state_index[3:0], item_i.trans_index, item_i.cond_index};

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start && item_i.cmd == CmdWrTrans && !item_i.state_index[4]) begin
      tmem[wr_slot] <= {(item_i.cond_count > 3'd4 ? 3'd4 : item_i.cond_count),
                        (item_i.target_state[4] ? NoState : item_i.target_state)};
    end
    if (ctrl_i.start && item_i.cmd == CmdWrCond && !item_i.state_index[4]) begin
      cmem[wr_cond] <= {item_i.var_index, item_i.comparator, item_i.value};
    end
    trd_q <= tmem[rd_slot];
    crd_q <= cmem[rd_cond];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tvalid_q <= '0;
      cur_q <= '0;
      vis_q <= '0;
      trd_v_q <= 1'b0;
      vars_q <= '{default: '0};
    end else begin
      trd_v_q <= tvalid_q[rd_slot];
      if (ctrl_i.start) begin
        vis_q <= '0;
        if (item_i.cmd == CmdSetVar) vars_q[item_i.var_index] <= item_i.value;
        unique case (item_i.cmd)
          CmdWrTrans: if (!item_i.state_index[4]) tvalid_q[wr_slot] <= item_i.slot_valid;
          CmdReset:   cur_q <= start_state_i[4] ? NoState : start_state_i;
          CmdSetCur:  cur_q <= item_i.state_index[4] ? NoState : item_i.state_index;
          default: ;
        endcase
      end
      if (ctrl_i.clr_vars) vars_q[ctrl_i.clr_idx] <= '0;
      if (ctrl_i.hop) vis_q[tgt_q] <= 1'b1;
      if (ctrl_i.finish && ctrl_i.status == StsMoved && it_q.cmd == CmdEval) cur_q <= walk_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      it_q <= item_i;
      walk_q <= cur_q;
    end
    if (ctrl_i.load_trans) tgt_q <= trd_q[4:0];
    if (ctrl_i.hop) walk_q <= tgt_q;
    if (ctrl_i.eval_cond) ok_q <= hold;
    if (ctrl_i.finish) begin
      status_q <= ctrl_i.status;
      var_q <= vars_q[it_q.var_index];
      // result copy, so a waiting result survives the next command
      res_cur_q <= (ctrl_i.status == StsMoved && it_q.cmd == CmdEval) ? walk_q : cur_q;
    end
  end

  assign a = vars_q[crd_q[38:35]];
  assign b = crd_q[31:0];
  always_comb begin
    unique case (crd_q[34:32])
      CmpEq: hold = a == b;
      CmpNe: hold = a != b;
      CmpGt: hold = a > b;
      CmpGe: hold = a >= b;
      CmpLt: hold = a < b;
      CmpLe: hold = a <= b;
      default: hold = 1'b0;
    endcase
  end

  assign stat_o.cur_none = cur_q[4];
  assign stat_o.slot_valid = trd_v_q;
  assign stat_o.slot_count = trd_q[7:5];
  assign stat_o.cond_ok = ok_q;
  assign stat_o.tgt_none = tgt_q[4];
  assign stat_o.tgt_visited = vis_q[tgt_q];
  assign stat_o.at_start = walk_q == cur_q;
  assign status_o = status_q;
  assign cur_o = res_cur_q;
  assign var_o = var_q;
endmodule

@@ design/gtf_ctrl.sv @@
// Controller: command sequencing and evaluate walk over slots and conditions.
// Depends on gtf_pkg and the assertion header.
`include "guarded_transition_fsm_engine_assert.svh"
module gtf_ctrl (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_fire_i,
  input  logic [2:0] cmd_i,
  input  logic out_busy_i,
  input  gtf_pkg::stat_t stat_i,
  output gtf_pkg::ctrl_t ctrl_o,
  output logic [1:0] trans_o,
  output logic [1:0] cond_o,
  output logic idle_o,
  output logic done_o
);
  import gtf_pkg::*;

  localparam logic [2:0] SIdle = 3'd0;
  localparam logic [2:0] SClr = 3'd1;
  localparam logic [2:0] STrRd = 3'd2;  // slot read address presented
  localparam logic [2:0] STrChk = 3'd3; // slot data available
  localparam logic [2:0] SCdRd = 3'd4;  // condition data available, compare
  localparam logic [2:0] SCdChk = 3'd5;
  localparam logic [2:0] SHop = 3'd6;
  localparam logic [2:0] SDone = 3'd7;

  logic [2:0] state_q, state_d;
  logic [1:0] tr_q, tr_d, cd_q, cd_d, sts_q, sts_d;
  logic [3:0] ci_q, ci_d;
  logic [2:0] cmd_q;
  // hop decision: no firing slot means target none, forced here
  logic no_fire_q, hop_ready;
  logic [1:0] hop_sts;

  always_comb begin
    state_d = state_q; tr_d = tr_q; cd_d = cd_q; sts_d = sts_q; ci_d = ci_q;
    ctrl_o = '0;
    ctrl_o.clr_idx = ci_q;
    ctrl_o.status = sts_q;
    unique case (state_q)
      SIdle: if (in_fire_i) begin
        ctrl_o.start = 1'b1;
        sts_d = StsMoved; tr_d = '0; cd_d = '0; ci_d = '0;
        priority if (cmd_i == CmdReset) state_d = SClr;
        else if (cmd_i == CmdEval && stat_i.cur_none) begin
          sts_d = StsNone; state_d = SDone;
        end else if (cmd_i == CmdEval) state_d = STrRd;
        else state_d = SDone;
      end
      SClr: begin
        ctrl_o.clr_vars = 1'b1;
        ci_d = ci_q + 4'd1;
        if (ci_q == 4'(NumVars - 1)) state_d = SDone;
      end
      STrRd: state_d = STrChk;
      STrChk: begin
        ctrl_o.load_trans = 1'b1;
        cd_d = '0;
        if (!stat_i.slot_valid) begin
          tr_d = tr_q + 2'd1;
          state_d = (tr_q == 2'(TransPerState - 1)) ? SHop : STrRd;
        end else if (stat_i.slot_count == 3'd0) state_d = SHop;
        else state_d = SCdRd;
      end
      SCdRd: begin ctrl_o.eval_cond = 1'b1; state_d = SCdChk; end
      SCdChk: begin
        if (!stat_i.cond_ok) begin
          tr_d = tr_q + 2'd1; cd_d = '0;
          state_d = (tr_q == 2'(TransPerState - 1)) ? SHop : STrRd;
        end else if ({1'b0, cd_q} + 3'd1 == stat_i.slot_count) state_d = SHop;
        else begin cd_d = cd_q + 2'd1; state_d = SCdRd; end
      end
      SHop: if (!no_fire_q) ctrl_o.hop = !stat_i.tgt_visited && !stat_i.tgt_none;
      SDone: begin
        ctrl_o.finish = !out_busy_i;
        state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle; tr_q <= '0; cd_q <= '0; sts_q <= '0; ci_q <= '0;
      cmd_q <= '0; no_fire_q <= 1'b0;
    end else begin
      if (state_q == SIdle && in_fire_i) cmd_q <= cmd_i;
      if (state_q == SHop) begin
        tr_q <= '0; cd_q <= '0;
        if (hop_ready) begin
          state_q <= SDone;
          sts_q <= hop_sts;
        end else state_q <= STrRd;
        no_fire_q <= 1'b0;
      end else begin
        state_q <= (state_q == SDone && out_busy_i) ? SDone : state_d;
        tr_q <= tr_d; cd_q <= cd_d; sts_q <= sts_d; ci_q <= ci_d;
        if ((state_q == STrChk && !stat_i.slot_valid && tr_q == 2'(TransPerState - 1)) ||
            (state_q == SCdChk && !stat_i.cond_ok && tr_q == 2'(TransPerState - 1)))
          no_fire_q <= 1'b1;
      end
    end
  end
  assign hop_ready = no_fire_q || stat_i.tgt_none || stat_i.tgt_visited;
  // with no firing slot the walk stops on none, which is never marked
  assign hop_sts = (!no_fire_q && stat_i.tgt_visited) ? StsLoop :
                   (stat_i.at_start ? StsSame : StsMoved);

  assign trans_o = tr_q;
  // condition read address runs one step ahead of the compare
  assign cond_o = cd_d;
  assign idle_o = state_q == SIdle;
  assign done_o = state_q == SDone && !out_busy_i;

  `GTF_ASSERT_IMP(a_start_idle, clk_i, rst_ni, ctrl_o.start, state_q == SIdle)
  `GTF_ASSERT_NEXT(a_done_idle, clk_i, rst_ni, done_o, state_q == SIdle)
  `GTF_ASSERT_NEXT(a_clr_wrap, clk_i, rst_ni, state_q == SClr && ci_q == 4'(NumVars - 1),
                   state_q == SDone)
  `GTF_ASSERT_IMP(a_evalcmd, clk_i, rst_ni, state_q == STrRd, cmd_q == CmdEval)
endmodule

@@ tb/guarded_transition_fsm_engine_test.sv @@
// Testbench for the guarded transition engine: directed and random commands,
// a behavioural predictor of the engine and an in-order result scoreboard.
// Depends on gtf_pkg and the guarded_transition_fsm_engine top level.
module guarded_transition_fsm_engine_test;
  timeunit 1ns;
  timeprecision 1ps;
  import gtf_pkg::*;

  typedef struct packed {
    logic [1:0] status;
    logic [4:0] cur;
    logic [31:0] var_value;
  } reply_t;

  // predictor of the engine, holding its own copy of every table
  class engine_scoreboard;
    logic [31:0] vars[NumVars];
    logic trans_ok[NumSlots];
    logic [4:0] trans_tgt[NumSlots];
    logic [2:0] trans_cnt[NumSlots];
    logic [3:0] cond_var[NumConds];
    logic [2:0] cond_cmp[NumConds];
    logic [31:0] cond_k[NumConds];
    logic [4:0] cur;
    logic [4:0] start_st;
    reply_t pending[$];
    int errors;
    int checked;
    int stat_seen[4];

    function new();
      foreach (vars[i]) vars[i] = '0;
      foreach (trans_ok[i]) begin
        trans_ok[i] = 1'b0;
        trans_tgt[i] = NoState;
        trans_cnt[i] = '0;
      end
      foreach (cond_var[i]) begin
        cond_var[i] = '0;
        cond_cmp[i] = CmpEq;
        cond_k[i] = '0;
      end
      cur = '0;
      start_st = '0;
      errors = 0;
      checked = 0;
      foreach (stat_seen[i]) stat_seen[i] = 0;
    endfunction

    function logic [4:0] clip(logic [4:0] s);
      return (s < NumStates) ? s : NoState;
    endfunction

    function bit guard_holds(int c);
      logic signed [31:0] a;
      logic signed [31:0] b;
      a = vars[cond_var[c]];
      b = cond_k[c];
      case (cond_cmp[c])
        CmpEq: return a == b;
        CmpNe: return a != b;
        CmpGt: return a > b;
        CmpGe: return a >= b;
        CmpLt: return a < b;
        CmpLe: return a <= b;
        default: return 1'b0;
      endcase
    endfunction

    function logic [4:0] first_target(logic [4:0] s);
      int slot;
      bit ok;
      for (int t = 0; t < TransPerState; t++) begin
        slot = s * TransPerState + t;
        if (trans_ok[slot]) begin
          ok = 1'b1;
          for (int k = 0; k < trans_cnt[slot]; k++)
            if (ok) ok = guard_holds(slot * CondsPerTrans + k);
          if (ok) return trans_tgt[slot];
        end
      end
      return NoState;
    endfunction

    function logic [1:0] walk();
      bit seen[NumStates+1];
      logic [4:0] st;
      logic [4:0] nx;
      if (cur >= NumStates) return StsNone;
      foreach (seen[i]) seen[i] = 1'b0;
      st = cur;
      nx = cur;
      while (nx < NumStates) begin
        st = nx;
        nx = first_target(st);
        if (seen[nx]) return StsLoop;
        seen[nx] = 1'b1;
      end
      if (st == cur) return StsSame;
      cur = st;
      return StsMoved;
    endfunction

    function void note_command(item_t it);
      reply_t r;
      int slot;
      r.status = StsMoved;
      slot = it.state_index * TransPerState + it.trans_index;
      case (it.cmd)
        CmdSetVar: vars[it.var_index] = it.value;
        CmdWrCond: if (it.state_index < NumStates) begin
          cond_var[slot * CondsPerTrans + it.cond_index] = it.var_index;
          cond_cmp[slot * CondsPerTrans + it.cond_index] = it.comparator;
          cond_k[slot * CondsPerTrans + it.cond_index] = it.value;
        end
        CmdWrTrans: if (it.state_index < NumStates) begin
          trans_ok[slot] = it.slot_valid;
          trans_tgt[slot] = clip(it.target_state);
          trans_cnt[slot] = (it.cond_count > CondsPerTrans) ? 3'(CondsPerTrans)
                                                             : it.cond_count;
        end
        CmdEval: r.status = walk();
        CmdReset: begin
          foreach (vars[i]) vars[i] = '0;
          cur = clip(start_st);
        end
        CmdSetCur: cur = clip(it.state_index);
        default: ;
      endcase
      r.cur = cur;
      r.var_value = vars[it.var_index];
      pending.insert(pending.size(), r);
    endfunction

    task check_reply(logic [39:0] d);
      reply_t got;
      reply_t exp;
      got.status = d[1:0];
      got.cur = d[6:2];
      got.var_value = d[38:7];
      if (pending.size() == 0) begin
        report("unexpected transaction", got, got);
        return;
      end
      exp = pending.pop_front();
      checked++;
      stat_seen[exp.status]++;
      if (got.status !== exp.status) report("status", got, exp);
      if (got.cur !== exp.cur) report("current_state", got, exp);
      if (got.var_value !== exp.var_value) report("var_value", got, exp);
    endtask

    task report(string what, reply_t got, reply_t exp);
      errors++;
      if (errors <= 30)
        $display("mismatch %0s: got st=%0d cur=%0d var=%0d, exp st=%0d cur=%0d var=%0d",
                 what, got.status, got.cur, $signed(got.var_value),
                 exp.status, exp.cur, $signed(exp.var_value));
    endtask
  endclass

  logic clk_i;
  logic rst_ni;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [63:0] s_axis_tdata;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [39:0] m_axis_tdata;
  logic cfg_we_i;
  logic [4:0] cfg_wdata_i;

  engine_scoreboard sb;
  bit sender_gaps;
  bit receiver_gaps;
  bit hold_off;
  int n_sent;
  // condition entries written so far
  bit written[NumConds];

  guarded_transition_fsm_engine DUT (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_we_i, .cfg_wdata_i
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("timeout");
    $display("status: fail");
    $finish;
  end

  // result side: random stall bursts, plus one long hold-off on request
  initial begin
    int gap;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) sb.check_reply(m_axis_tdata);
      if (hold_off) begin
        m_axis_tready <= 1'b0;
        repeat (200) @(posedge clk_i);
        hold_off = 1'b0;
        m_axis_tready <= 1'b1;
      end else if (receiver_gaps && $urandom_range(0, 3) == 0) begin
        gap = $urandom_range(1, 3);
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
        if (m_axis_tvalid && m_axis_tready) sb.check_reply(m_axis_tdata);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  function automatic logic [63:0] pack_item(item_t it);
    return {4'b0, it.slot_valid, it.cond_count, it.target_state, it.comparator,
            it.cond_index, it.trans_index, it.state_index, it.value,
            it.var_index, it.cmd};
  endfunction

  // tvalid stays high between back-to-back transactions
  task automatic send(item_t it);
    int gap;
    if (sender_gaps && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 3);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tdata <= pack_item(it);
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_command(it);
    n_sent++;
  endtask

  function automatic item_t blank(logic [2:0] cmd);
    item_t it;
    it = 60'({$urandom, $urandom});
    it.cmd = cmd;
    return it;
  endfunction

  task automatic set_var(int v, logic [31:0] x);
    item_t it;
    it = blank(CmdSetVar);
    it.var_index = 4'(v);
    it.value = x;
    send(it);
  endtask

  task automatic wr_cond(int s, int t, int c, int v, logic [2:0] cmp, logic [31:0] k);
    item_t it;
    it = blank(CmdWrCond);
    it.state_index = 5'(s);
    it.trans_index = 2'(t);
    it.cond_index = 2'(c);
    it.var_index = 4'(v);
    it.comparator = cmp;
    it.value = k;
    written[(s * TransPerState + t) * CondsPerTrans + c] = 1'b1;
    send(it);
  endtask

  // all conditions a transition may use are written first
  task automatic wr_trans(int s, int t, int tgt, int cnt, bit ok);
    item_t it;
    int lim;
    lim = (cnt > CondsPerTrans) ? CondsPerTrans : cnt;
    for (int k = 0; k < lim; k++)
      if (!written[(s * TransPerState + t) * CondsPerTrans + k])
        wr_cond(s, t, k, $urandom_range(0, 15), 3'($urandom_range(0, 7)),
                $urandom_range(0, 3));
    it = blank(CmdWrTrans);
    it.state_index = 5'(s);
    it.trans_index = 2'(t);
    it.target_state = 5'(tgt);
    it.cond_count = 3'(cnt);
    it.slot_valid = ok;
    send(it);
  endtask

  task automatic simple(logic [2:0] cmd, int st);
    item_t it;
    it = blank(cmd);
    it.state_index = 5'(st);
    send(it);
  endtask

  // written only with the engine idle and every result back
  task automatic write_start(logic [4:0] s);
    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (NumVars + 8) @(posedge clk_i);
    cfg_wdata_i <= s;
    cfg_we_i <= 1'b1;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.start_st = s;
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return $urandom;
      default: return $urandom_range(0, 6) - 3;
    endcase
  endfunction

  task automatic random_item();
    item_t it;
    int s;
    int t;
    s = $urandom_range(0, 9) == 0 ? $urandom_range(16, 31) : $urandom_range(0, 5);
    t = $urandom_range(0, 3);
    case ($urandom_range(0, 11))
      0, 1: set_var($urandom_range(0, 15), pick_value());
      2, 3: begin
        if (s < NumStates)
          wr_cond(s, t, $urandom_range(0, 3), $urandom_range(0, 15),
                  3'($urandom_range(0, 7)), pick_value());
        else begin
          it = blank(CmdWrCond);
          it.state_index = 5'(s);
          send(it);
        end
      end
      4, 5: begin
        if (s < NumStates)
          wr_trans(s, t, $urandom_range(0, 9) == 0 ? $urandom_range(16, 31)
                         : $urandom_range(0, 5), $urandom_range(0, 7), $urandom_range(0, 4) != 0);
        else begin
          it = blank(CmdWrTrans);
          it.state_index = 5'(s);
          send(it);
        end
      end
      6, 7, 8: simple(CmdEval, 0);
      9: simple(CmdReset, 0);
      10: simple(CmdSetCur, s);
      default: simple(3'($urandom_range(6, 7)), 0);
    endcase
  endtask

  initial begin
    sb = new();
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    sender_gaps = 1'b0;
    receiver_gaps = 1'b0;
    hold_off = 1'b0;
    n_sent = 0;
    foreach (written[i]) written[i] = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, comparators, stop target, loop, none, unused codes
    simple(CmdEval, 0);
    set_var(0, 32'h8000_0000);
    set_var(15, 32'h7fff_ffff);
    wr_cond(0, 0, 0, 0, CmpLt, 32'h7fff_ffff);
    wr_cond(0, 0, 1, 15, CmpGe, 32'h8000_0000);
    wr_cond(0, 0, 2, 3, CmpEq, 0);
    wr_cond(0, 0, 3, 15, CmpLe, 32'h7fff_ffff);
    wr_trans(0, 0, 1, 7, 1);
    wr_cond(1, 0, 0, 0, CmpGt, 0);
    wr_cond(1, 1, 0, 0, CmpNe, 0);
    wr_trans(1, 0, 2, 1, 1);
    wr_trans(1, 1, 0, 1, 1);
    simple(CmdEval, 0);
    wr_cond(1, 2, 0, 1, 3'd6, 0);
    wr_trans(1, 2, 31, 1, 1);
    wr_trans(1, 3, 31, 0, 1);
    simple(CmdEval, 0);
    simple(CmdEval, 0);
    wr_trans(3, 3, 16, 0, 0);
    simple(CmdSetCur, 16);
    simple(CmdEval, 0);
    simple(CmdSetCur, 31);
    simple(3'd6, 0);
    simple(3'd7, 0);
    write_start(5'd31);
    simple(CmdReset, 0);
    simple(CmdEval, 0);
    write_start(5'd1);
    simple(CmdReset, 0);

    sender_gaps = 1'b1;
    receiver_gaps = 1'b1;
    for (int phase = 0; phase < 4; phase++) begin
      for (int i = 0; i < 85; i++) begin
        if (phase == 1 && i == 10) hold_off = 1'b1;
        if (phase == 3 && i == 50) begin
          sender_gaps = 1'b0;
          receiver_gaps = 1'b0;
        end
        random_item();
      end
      if (phase < 3) write_start(phase == 0 ? 5'd15 : (phase == 1 ? 5'd0 : 5'd16));
      if (phase < 3) simple(CmdReset, 0);
    end

    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    $display("%0d commands sent, %0d results checked", n_sent, sb.checked);
    $display("status codes returned: moved/done %0d, unchanged %0d, none %0d, loop %0d",
             sb.stat_seen[0], sb.stat_seen[1], sb.stat_seen[2], sb.stat_seen[3]);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end
endmodule

@@ sim.f @@
+incdir+design
design/gtf_pkg.sv
design/gtf_datapath.sv
design/gtf_ctrl.sv
design/guarded_transition_fsm_engine.sv
tb/guarded_transition_fsm_engine_test.sv
